// ===== hdl/lrpp_pkg.sv =====
package lrpp_pkg;

    localparam int LEN_W = 13;
    localparam int PRIO_W = 8;
    localparam int COLOR_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PRIORITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY_BIT = 2'd2;

    localparam logic [7:0] RST_DEFAULT_PRIORITY = 8'd6;
    localparam logic [7:0] RST_LEVEL_MASK = 8'd7;
    localparam logic [2:0] RST_BINARY_BIT = 3'd7;

    typedef enum logic [1:0] {
        ST_FORMATTED = 2'd0,
        ST_UNFORMATTED = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_PNAME = 3'd0,
        PH_TNAME = 3'd1,
        PH_PRIO = 3'd2,
        PH_TAG = 3'd3,
        PH_MSG = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
        logic       separate_thread;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [LEN_W-1:0]     pname_len;
        logic [LEN_W-1:0]     tname_len;
        logic [LEN_W-1:0]     tag_start;
        logic [LEN_W-1:0]     tag_len;
        logic [LEN_W-1:0]     message_start;
        logic [LEN_W-1:0]     message_len;
        logic [PRIO_W-1:0]    priority_res;
        logic                 binary_msg;
        logic [COLOR_W-1:0]   color;
    } t_out_item;

endpackage

// ===== hdl/log_record_payload_parser.sv =====
// Log record payload parser. Bytes of one record enter one per cycle on the input channel, the
// last one flagged; the block follows the process name, the optional thread name (taken when
// separate_thread is high at the byte that ends the process name), the four priority bytes, the
// tag and the message, and on the last byte delivers one result with status, offsets, lengths,
// priority, binary flag and color. Nothing else comes out for the other bytes. A new byte is
// taken every cycle unless the input stalls; each byte is held in the input register and its
// result is loaded into the result register when the last byte is processed. The input stalls
// only while a last byte in the input register meets a result still waiting at the output.
// Bytes beyond MAX_PAYLOAD are dropped and only their last flag matters. Configuration is
// written through a plain write port and must only change while no record is in flight.
module log_record_payload_parser #(
    parameter int MAX_PAYLOAD = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lrpp_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lrpp_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [lrpp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lrpp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lrpp_pkg::*;

    localparam int OW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = OW + 1;

    // configuration
    logic [7:0] r_default_priority;
    logic [7:0] r_level_mask;
    logic [2:0] r_binary_bit;

    // input register
    logic     r_s1_valid;
    t_in_item r_s1_item;

    // parse state
    t_phase        r_phase, n_phase;
    logic [OW-1:0] r_byte_offset, n_byte_offset;
    logic [OW-1:0] r_pname_len, n_pname_len;
    logic [OW-1:0] r_tname_len, n_tname_len;
    logic [OW-1:0] r_region_start, n_region_start;
    logic [7:0]    r_prio [4];
    logic [7:0]    n_prio [4];
    logic          r_fna_seen, n_fna_seen;
    logic [OW-1:0] r_fna, n_fna;
    logic          r_tag_end_seen, n_tag_end_seen;
    logic [OW-1:0] r_tag_end, n_tag_end;
    logic          r_mfn_seen, n_mfn_seen;
    logic [OW-1:0] r_mfn, n_mfn;

    // result register
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_result;

    logic s1_go;
    logic proc;
    logic in_fire;

    assign s1_go = !(r_s1_item.last_byte && r_out_valid && !i_out_ready);
    assign proc = r_s1_valid && s1_go;
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_fire = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_priority <= RST_DEFAULT_PRIORITY;
            r_level_mask <= RST_LEVEL_MASK;
            r_binary_bit <= RST_BINARY_BIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEFAULT_PRIORITY: r_default_priority <= i_cfg_data;
                CFG_LEVEL_MASK:       r_level_mask <= i_cfg_data;
                CFG_BINARY_BIT:       r_binary_bit <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (proc) begin
            r_s1_valid <= 1'b0;
        end
        if (in_fire) begin
            r_s1_item <= i_in_item;
        end
    end

    always_comb begin
        logic          take;
        logic [OW-1:0] pos;
        logic [OW-1:0] rel;
        logic [7:0]    b;
        logic [AW-1:0] total;
        logic [AW-1:0] ulen;
        logic [AW-1:0] tstart;
        logic [AW-1:0] mstart;
        logic [AW-1:0] msize;
        logic [AW-1:0] mlen;
        logic          bin;

        n_phase = r_phase;
        n_byte_offset = r_byte_offset;
        n_pname_len = r_pname_len;
        n_tname_len = r_tname_len;
        n_region_start = r_region_start;
        n_prio = r_prio;
        n_fna_seen = r_fna_seen;
        n_fna = r_fna;
        n_tag_end_seen = r_tag_end_seen;
        n_tag_end = r_tag_end;
        n_mfn_seen = r_mfn_seen;
        n_mfn = r_mfn;

        pos = r_byte_offset;
        rel = pos - r_region_start;
        b = r_s1_item.payload_byte;
        take = proc && (r_byte_offset < OW'(MAX_PAYLOAD));

        if (take) begin
            n_byte_offset = pos + OW'(1);
            case (r_phase)
                PH_PNAME: begin
                    if (b == 8'd0) begin
                        n_pname_len = pos;
                        n_region_start = pos + OW'(1);
                        if (r_s1_item.separate_thread) begin
                            n_phase = PH_TNAME;
                        end else begin
                            n_tname_len = pos;
                            n_phase = PH_PRIO;
                        end
                    end
                end
                PH_TNAME: begin
                    if (b == 8'd0) begin
                        n_tname_len = rel;
                        n_region_start = pos + OW'(1);
                        n_phase = PH_PRIO;
                    end
                end
                PH_PRIO: begin
                    n_prio[rel[1:0]] = b;
                    if (b == 8'd0 && !r_fna_seen) begin
                        n_fna_seen = 1'b1;
                        n_fna = pos;
                    end
                    if (rel >= OW'(3)) begin
                        n_phase = PH_TAG;
                    end
                end
                PH_TAG: begin
                    if (b == 8'd0) begin
                        if (!r_fna_seen) begin
                            n_fna_seen = 1'b1;
                            n_fna = pos;
                        end
                        n_tag_end_seen = 1'b1;
                        n_tag_end = pos;
                        n_phase = PH_MSG;
                    end
                end
                default: begin
                    if (b == 8'd0 && !r_mfn_seen) begin
                        n_mfn_seen = 1'b1;
                        n_mfn = pos;
                    end
                end
            endcase
        end

        // result from the state including this byte
        total = AW'(n_byte_offset);
        ulen = n_fna_seen ? (AW'(n_fna) - AW'(n_region_start))
                          : (total - AW'(n_region_start));
        tstart = AW'(n_region_start) + AW'(4);
        mstart = AW'(n_tag_end) + AW'(1);
        msize = total - mstart;
        bin = n_prio[0][r_binary_bit];
        mlen = msize;
        if (!bin && n_mfn_seen) begin
            mlen = AW'(n_mfn) - mstart + AW'(1);
        end

        n_result = '0;
        n_result.status = ST_MALFORMED;
        case (n_phase)
            PH_PNAME, PH_TNAME: begin
                n_result.status = ST_MALFORMED;
            end
            PH_PRIO, PH_TAG: begin
                n_result.status = ST_UNFORMATTED;
                n_result.pname_len = LEN_W'(n_pname_len);
                n_result.tname_len = LEN_W'(n_tname_len);
                n_result.message_start = LEN_W'(n_region_start);
                n_result.message_len = LEN_W'(ulen + AW'(1));
                n_result.priority_res = r_default_priority;
            end
            default: begin
                // empty text message is malformed
                if (bin || msize != '0) begin
                    n_result.status = ST_FORMATTED;
                    n_result.pname_len = LEN_W'(n_pname_len);
                    n_result.tname_len = LEN_W'(n_tname_len);
                    n_result.tag_start = LEN_W'(tstart);
                    n_result.tag_len = LEN_W'(AW'(n_tag_end) - tstart);
                    n_result.message_start = LEN_W'(mstart);
                    n_result.message_len = LEN_W'(mlen);
                    n_result.priority_res = n_prio[0] & r_level_mask;
                    n_result.binary_msg = bin;
                    n_result.color = {n_prio[3], n_prio[2], n_prio[1]};
                end
            end
        endcase

        if (proc && r_s1_item.last_byte) begin
            n_phase = PH_PNAME;
            n_byte_offset = '0;
            n_fna_seen = 1'b0;
            n_tag_end_seen = 1'b0;
            n_mfn_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PNAME;
            r_byte_offset <= '0;
            r_fna_seen <= 1'b0;
            r_tag_end_seen <= 1'b0;
            r_mfn_seen <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_byte_offset <= n_byte_offset;
            r_fna_seen <= n_fna_seen;
            r_tag_end_seen <= n_tag_end_seen;
            r_mfn_seen <= n_mfn_seen;
        end
        r_pname_len <= n_pname_len;
        r_tname_len <= n_tname_len;
        r_region_start <= n_region_start;
        r_prio <= n_prio;
        r_fna <= n_fna;
        r_tag_end <= n_tag_end;
        r_mfn <= n_mfn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_s1_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc && r_s1_item.last_byte) begin
            r_out_item <= n_result;
        end
    end

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_offset <= OW'(MAX_PAYLOAD))
        else $error("byte offset past payload limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_s1_item.last_byte) |=> (r_phase == PH_PNAME && r_byte_offset == '0
            && !r_fna_seen && !r_mfn_seen))
        else $error("parse state not cleared after last byte");

    a_msg_in_tag_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MSG) |-> r_tag_end_seen)
        else $error("message phase without tag end");

    a_malformed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status == ST_MALFORMED) |->
            (r_out_item.pname_len == '0 && r_out_item.message_len == '0
             && r_out_item.priority_res == '0 && r_out_item.color == '0))
        else $error("malformed result carries data");

    a_formatted_layout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status == ST_FORMATTED) |->
            (r_out_item.message_start
             == LEN_W'(r_out_item.tag_start + r_out_item.tag_len + LEN_W'(1))))
        else $error("message does not follow tag terminator");

    a_unformatted_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status == ST_UNFORMATTED) |->
            (!r_out_item.binary_msg && r_out_item.color == '0 && r_out_item.tag_len == '0))
        else $error("unformatted result carries tag data");

endmodule
